/* hdl/scp_pkg.sv */
// Package with the word types, stage records and constants of the soft-core Coulomb block.
package scp_pkg;

	localparam int unsigned CoordW  = 24;
	localparam int unsigned DistW   = 50;
	localparam int unsigned RadW    = 64;
	localparam int unsigned RootW   = 32;
	localparam int unsigned SqRemW  = 34;
	localparam int unsigned NumW    = 47;
	localparam int unsigned DivRemW = 32;
	localparam int unsigned SqSteps = RadW / 2;
	localparam int unsigned DivSteps = NumW;

	localparam logic [1:0] RegCharge = 2'd0;
	localparam logic [1:0] RegSoft   = 2'd1;
	localparam logic [1:0] RegTwoDim = 2'd2;

	typedef struct packed {
		logic signed [CoordW-1:0] first_x;
		logic signed [CoordW-1:0] first_y;
		logic signed [CoordW-1:0] second_x;
		logic signed [CoordW-1:0] second_y;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] potential;
		logic               saturated;
	} out_word_t;

	typedef struct packed {
		logic [RadW-1:0]   rad;
		logic [SqRemW-1:0] rem;
		logic [RootW-1:0]  root;
	} sqrt_rec_t;

	typedef struct packed {
		logic [NumW-1:0]    num;
		logic [DivRemW-1:0] rem;
		logic [NumW-1:0]    quot;
		logic [RootW-1:0]   divisor;
	} div_rec_t;

endpackage

/* hdl/scp_sqrt_stage.sv */
// One register stage of the digit-by-digit integer square root.
module scp_sqrt_stage
	import scp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid_in,
	input  sqrt_rec_t rec_in,
	output logic      valid_out,
	output sqrt_rec_t rec_out
);

	logic [SqRemW+1:0] rem_sh;
	logic [SqRemW+1:0] trial;
	sqrt_rec_t         nxt;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rec_in.rem, rec_in.rad[RadW-1 -: 2]};
		trial  = {2'b00, rec_in.root, 2'b01};
		nxt.rad = {rec_in.rad[RadW-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = SqRemW'(rem_sh - trial);
			nxt.root = {rec_in.root[RootW-2:0], 1'b1};
		end else begin
			nxt.rem  = SqRemW'(rem_sh);
			nxt.root = {rec_in.root[RootW-2:0], 1'b0};
		end
	end

	// Valid bit, reset with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (en) begin
			rec_out <= nxt;
		end
	end

endmodule

/* hdl/scp_div_stage.sv */
// One register stage of the restoring divider, one quotient bit per stage.
module scp_div_stage
	import scp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     valid_in,
	input  div_rec_t rec_in,
	output logic     valid_out,
	output div_rec_t rec_out
);

	logic [DivRemW:0] rem_sh;
	div_rec_t         nxt;

	// Shift in the next numerator bit and subtract when the divisor fits.
	always_comb begin
		rem_sh      = {rec_in.rem, rec_in.num[NumW-1]};
		nxt.num     = {rec_in.num[NumW-2:0], 1'b0};
		nxt.divisor = rec_in.divisor;
		if (rem_sh >= {1'b0, rec_in.divisor}) begin
			nxt.rem  = DivRemW'(rem_sh - {1'b0, rec_in.divisor});
			nxt.quot = {rec_in.quot[NumW-2:0], 1'b1};
		end else begin
			nxt.rem  = DivRemW'(rem_sh);
			nxt.quot = {rec_in.quot[NumW-2:0], 1'b0};
		end
	end

	// Valid bit, reset with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (en) begin
			rec_out <= nxt;
		end
	end

endmodule

/* hdl/soft_coulomb_pair_potential.sv */
// Top level of the soft-core Coulomb pair potential pipeline.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | in_word  (in_word_t)
//   out     | out_valid / out_stall| out_word (out_word_t)
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word enters per cycle while the output is not stalled. The pipeline
// has three front stages (difference, square, sum), 32 square root stages,
// 47 divider stages (one per quotient bit) and the output register.
// Reset clears all valid bits and loads the register defaults.
// While the output word is stalled the whole pipeline holds, and in_stall
// follows; bubbles never advance ahead of a stalled word.
module soft_coulomb_pair_potential
	import scp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	logic signed [CoordW-1:0] charge_q;
	logic [DistW-3:0]         soft_q;
	logic                     two_dim_q;
	logic                     adv;

	logic                     v_s1, v_s2, v_s3;
	logic [CoordW:0]          adx_s1, ady_s1;
	logic [DistW-1:0]         sqx_s2, sqy_s2;
	logic [DistW-1:0]         dist_s3;

	logic                     sq_v [SqSteps+1];
	sqrt_rec_t                sq_r [SqSteps+1];
	logic                     dv_v [DivSteps+1];
	div_rec_t                 dv_r [DivSteps+1];

	logic signed [CoordW:0]   dx, dy;
	logic [CoordW-1:0]        cmag;
	logic                     neg;
	logic [NumW-1:0]          q;
	out_word_t                res;

	assign cfg_ready = 1'b1;
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q  <= CoordW'(4096);
			soft_q    <= (DistW-2)'(48'h1000000);
			two_dim_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegCharge: charge_q  <= cfg_data[CoordW-1:0];
				RegSoft:   soft_q    <= cfg_data;
				RegTwoDim: two_dim_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Coordinate differences; their magnitudes are registered in the first front stage.
	always_comb begin
		dx = {in_word.second_x[CoordW-1], in_word.second_x}
			- {in_word.first_x[CoordW-1], in_word.first_x};
		dy = {in_word.second_y[CoordW-1], in_word.second_y}
			- {in_word.first_y[CoordW-1], in_word.first_y};
	end

	// Front stages: magnitude, square, sum with softening.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adx_s1  <= dx[CoordW] ? (CoordW+1)'(-dx) : dx;
			ady_s1  <= !two_dim_q ? '0 : (dy[CoordW] ? (CoordW+1)'(-dy) : dy);
			sqx_s2  <= adx_s1 * adx_s1;
			sqy_s2  <= ady_s1 * ady_s1;
			dist_s3 <= sqx_s2 + sqy_s2 + {2'b00, soft_q};
		end
	end

	// Square root chain over the distance term scaled by 2^14.
	assign sq_v[0]      = v_s3;
	assign sq_r[0].rad  = {dist_s3, 14'b0};
	assign sq_r[0].rem  = '0;
	assign sq_r[0].root = '0;

	for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
		scp_sqrt_stage u_sqrt (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_in(sq_v[i]), .rec_in(sq_r[i]),
			.valid_out(sq_v[i+1]), .rec_out(sq_r[i+1])
		);
	end

	// Divider chain: |charge| * 2^23 over the root.
	assign neg  = charge_q[CoordW-1];
	assign cmag = neg ? CoordW'(-charge_q) : charge_q;

	assign dv_v[0]         = sq_v[SqSteps];
	assign dv_r[0].num     = {cmag, 23'b0};
	assign dv_r[0].rem     = '0;
	assign dv_r[0].quot    = '0;
	assign dv_r[0].divisor = sq_r[SqSteps].root;

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		scp_div_stage u_div (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_in(dv_v[j]), .rec_in(dv_r[j]),
			.valid_out(dv_v[j+1]), .rec_out(dv_r[j+1])
		);
	end

	// Sign, saturation and the zero denominator.
	always_comb begin
		q = dv_r[DivSteps].quot;
		res.saturated = 1'b1;
		res.potential = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
		priority if (dv_r[DivSteps].divisor == '0) begin
			res.saturated = 1'b1;
		end else if (!neg && q > NumW'(32'h7FFFFFFF)) begin
			res.saturated = 1'b1;
		end else if (neg && q > NumW'(32'h80000000)) begin
			res.saturated = 1'b1;
		end else begin
			res.saturated = 1'b0;
			res.potential = neg ? -q[31:0] : q[31:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_v[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word <= res;
		end
	end

endmodule
